// ===== hw/rtl/dcp_pkg.sv =====
`timescale 1ns / 1ps

package dcp_pkg;

    // Default geometry limits for the column and row counters.
    localparam int DEF_MAX_COLUMNS = 4096;
    localparam int DEF_MAX_ROWS    = 4096;

    // Field widths.
    localparam int DEPTH_W   = 16;
    localparam int COLOR_W   = 32;
    localparam int COORD_W   = 32;
    localparam int Z_W       = 23;
    localparam int INV_W     = 24;
    localparam int CENTER_W  = 16;
    localparam int ROW_LEN_W = 13;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Register reset values.
    localparam logic [INV_W-1:0]     RST_INV_FOCAL_X = 24'd28234;
    localparam logic [INV_W-1:0]     RST_INV_FOCAL_Y = 24'd28386;
    localparam logic [CENTER_W-1:0]  RST_CENTER_X    = 16'd5429;
    localparam logic [CENTER_W-1:0]  RST_CENTER_Y    = 16'd3884;
    localparam logic [ROW_LEN_W-1:0] RST_ROW_LENGTH  = 13'd512;

    // Depth to meters: z = floor(depth * 8192 / 125), done as
    // (depth * ceil(2^36 / 125)) >> 23, which is exact for 16-bit depths.
    localparam int               Z_RECIP_W = 30;
    localparam logic [29:0]      Z_RECIP   = 30'd549755814;
    localparam int               ZP_W      = DEPTH_W + Z_RECIP_W;
    localparam int               Z_SHIFT   = 23;

    // Fraction bits dropped after the reciprocal focal multiply.
    localparam int FRAC_SHIFT = 28;
    // Low slice width of the distance product for the split multiply.
    localparam int SPLIT_W    = 22;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_FOCAL_X = 3'd0,
        REG_INV_FOCAL_Y = 3'd1,
        REG_CENTER_X    = 3'd2,
        REG_CENTER_Y    = 3'd3,
        REG_ROW_LENGTH  = 3'd4
    } cfg_reg_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIST,
        ST_PART,
        ST_SUM,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_mm;
        logic [COLOR_W-1:0] color_bgra;
        logic               frame_start;
    } pixel_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [Z_W-1:0]            point_z;
        logic [COLOR_W-1:0]        color_out;
        logic                      row_end;
    } point_t;

    typedef struct packed {
        logic load_in;
        logic distance;
        logic part;
        logic sum;
        logic load_out;
    } ctrl_cmd_t;

endpackage

// ===== hw/rtl/depth_color_to_point_xyzrgba.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Word
// pixel     in         pixel_valid/stall     depth_mm, color_bgra, frame_start
// point     out        point_valid/stall     point_x, point_y, point_z, color_out, row_end
// cfg       in         cfg_wr_en             cfg_index, cfg_data
//
// One pixel is in flight at a time. The point word is made in these steps, the
// last once the output is free: depth scale multiply at accept, then distance
// multiply, split focal multiply, partial sum, and round and load. A new pixel
// is taken only once the previous word is loaded. A stalled point word delays
// the load of the next one, and the pixel side stays stalled until then. The
// result register lets a new pixel start while the previous word waits. Reset
// clears the row and column counters and loads the default camera registers.

module depth_color_to_point_xyzrgba
#(
    parameter int MAX_COLUMNS = dcp_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = dcp_pkg::DEF_MAX_ROWS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pixel_valid,
    output logic                            pixel_stall,
    input  dcp_pkg::pixel_t                 pixel,
    output logic                            point_valid,
    input  logic                            point_stall,
    output dcp_pkg::point_t                 point,
    input  logic                            cfg_wr_en,
    input  logic [dcp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dcp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dcp_pkg::*;

    ctrl_cmd_t cmd;

    dcp_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .cmd         (cmd)
    );

    dcp_datapath
    #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .pixel     (pixel),
        .point     (point),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ===== hw/rtl/dcp_ctrl.sv =====
`timescale 1ns / 1ps

module dcp_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pixel_valid,
    output logic               pixel_stall,
    output logic               point_valid,
    input  logic               point_stall,
    output dcp_pkg::ctrl_cmd_t cmd
);
    import dcp_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !point_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pixel_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DIST;
                end
            end
            ST_DIST:
            begin
                cmd.distance = 1'b1;
                state_next   = ST_PART;
            end
            ST_PART:
            begin
                cmd.part   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // The result register frees up in the same cycle its word is taken.
                if (!out_valid_reg || !point_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign pixel_stall = (state_reg != ST_IDLE);
    assign point_valid = out_valid_reg;

endmodule

// ===== hw/rtl/dcp_datapath.sv =====
`timescale 1ns / 1ps

module dcp_datapath
#(
    parameter int MAX_COLUMNS = dcp_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = dcp_pkg::DEF_MAX_ROWS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  dcp_pkg::ctrl_cmd_t              cmd,
    input  dcp_pkg::pixel_t                 pixel,
    output dcp_pkg::point_t                 point,
    input  logic                            cfg_wr_en,
    input  logic [dcp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dcp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dcp_pkg::*;

    localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int LW  = (CW + 1 > ROW_LEN_W) ? CW + 1 : ROW_LEN_W;
    localparam int XW  = (CW + 4 > CENTER_W) ? CW + 4 : CENTER_W;
    localparam int YW  = (RW + 4 > CENTER_W) ? RW + 4 : CENTER_W;
    localparam int TXW = Z_W + XW;
    localparam int TYW = Z_W + YW;
    localparam int PXW = TXW + INV_W;
    localparam int PYW = TYW + INV_W;
    localparam int PMW = (PXW > PYW) ? PXW : PYW;
    localparam int QW  = PMW - FRAC_SHIFT + 1;

    // Configuration registers.
    logic [INV_W-1:0]     inv_focal_x_reg;
    logic [INV_W-1:0]     inv_focal_y_reg;
    logic [CENTER_W-1:0]  center_x_reg;
    logic [CENTER_W-1:0]  center_y_reg;
    logic [ROW_LEN_W-1:0] row_length_reg;

    // Raster position.
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;

    // Per-pixel work registers.
    logic [ZP_W-1:0]              zp_reg;
    logic [Z_W-1:0]               z_reg;
    logic                         x_neg_reg;
    logic [XW-1:0]                x_mag_reg;
    logic                         y_neg_reg;
    logic [YW-1:0]                y_mag_reg;
    logic                         row_end_reg;
    logic [COLOR_W-1:0]           color_reg;
    logic [TXW-1:0]               tx_reg;
    logic [TYW-1:0]               ty_reg;
    logic [SPLIT_W+INV_W-1:0]     px_lo_reg;
    logic [TXW-SPLIT_W+INV_W-1:0] px_hi_reg;
    logic [SPLIT_W+INV_W-1:0]     py_lo_reg;
    logic [TYW-SPLIT_W+INV_W-1:0] py_hi_reg;
    logic [PXW-1:0]               px_reg;
    logic [PYW-1:0]               py_reg;
    point_t                       point_reg;

    // Position logic at accept.
    logic [CW-1:0]     col_cur;
    logic [RW-1:0]     row_cur;
    logic [LW-1:0]     len_raw;
    logic [LW-1:0]     len_eff;
    logic              last;
    logic              row_wrap;
    logic [XW:0]       col_x16;
    logic [XW:0]       cx_ext;
    logic [YW:0]       row_x16;
    logic [YW:0]       cy_ext;
    logic              x_neg;
    logic [XW-1:0]     x_mag;
    logic              y_neg;
    logic [YW-1:0]     y_mag;
    logic [Z_W-1:0]    z_cur;

    // Drops the fraction rounding toward minus infinity, applies the sign and
    // saturates to the signed coordinate range.
    function automatic logic [COORD_W-1:0] fix_coord(input logic [PMW-1:0] prod,
                                                     input logic neg);
        logic [QW-1:0]      q;
        logic [COORD_W-1:0] res;
        q = QW'(prod[PMW-1:FRAC_SHIFT]);
        if (neg)
        begin
            q = q + QW'(|prod[FRAC_SHIFT-1:0]);
            if (q >= (QW'(1) << (COORD_W - 1)))
            begin
                res = {1'b1, {(COORD_W - 1){1'b0}}};
            end
            else
            begin
                res = COORD_W'(0) - q[COORD_W-1:0];
            end
        end
        else
        begin
            if (q > QW'({(COORD_W - 1){1'b1}}))
            begin
                res = {1'b0, {(COORD_W - 1){1'b1}}};
            end
            else
            begin
                res = q[COORD_W-1:0];
            end
        end
        return res;
    endfunction

    always_comb
    begin
        col_cur = pixel.frame_start ? '0 : col_reg;
        row_cur = pixel.frame_start ? '0 : row_reg;

        // A zero length acts as one, and lengths beyond the counter range clamp.
        len_raw = LW'(row_length_reg);
        if (len_raw == '0)
        begin
            len_eff = LW'(1);
        end
        else if (len_raw > LW'(MAX_COLUMNS))
        begin
            len_eff = LW'(MAX_COLUMNS);
        end
        else
        begin
            len_eff = len_raw;
        end

        // A column already past the row length also ends the row.
        last     = (LW'(col_cur) + LW'(1)) >= len_eff;
        row_wrap = ((RW + 1)'(row_cur) + (RW + 1)'(1)) >= (RW + 1)'(MAX_ROWS);
        col_next = last ? '0 : col_cur + CW'(1);
        if (last)
        begin
            row_next = row_wrap ? '0 : row_cur + RW'(1);
        end
        else
        begin
            row_next = row_cur;
        end

        col_x16 = (XW + 1)'({col_cur, 4'b0000});
        cx_ext  = (XW + 1)'(center_x_reg);
        x_neg   = col_x16 < cx_ext;
        x_mag   = x_neg ? XW'(cx_ext - col_x16) : XW'(col_x16 - cx_ext);

        row_x16 = (YW + 1)'({row_cur, 4'b0000});
        cy_ext  = (YW + 1)'(center_y_reg);
        y_neg   = cy_ext < row_x16;
        y_mag   = y_neg ? YW'(row_x16 - cy_ext) : YW'(cy_ext - row_x16);

        z_cur = zp_reg[ZP_W-1:Z_SHIFT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_focal_x_reg <= RST_INV_FOCAL_X;
            inv_focal_y_reg <= RST_INV_FOCAL_Y;
            center_x_reg    <= RST_CENTER_X;
            center_y_reg    <= RST_CENTER_Y;
            row_length_reg  <= RST_ROW_LENGTH;
            col_reg         <= '0;
            row_reg         <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_INV_FOCAL_X: inv_focal_x_reg <= cfg_data[INV_W-1:0];
                    REG_INV_FOCAL_Y: inv_focal_y_reg <= cfg_data[INV_W-1:0];
                    REG_CENTER_X:    center_x_reg    <= cfg_data[CENTER_W-1:0];
                    REG_CENTER_Y:    center_y_reg    <= cfg_data[CENTER_W-1:0];
                    REG_ROW_LENGTH:  row_length_reg  <= cfg_data[ROW_LEN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.load_in)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            zp_reg      <= ZP_W'(pixel.depth_mm) * ZP_W'(Z_RECIP);
            x_neg_reg   <= x_neg;
            x_mag_reg   <= x_mag;
            y_neg_reg   <= y_neg;
            y_mag_reg   <= y_mag;
            row_end_reg <= last;
            color_reg   <= pixel.color_bgra;
        end
        if (cmd.distance)
        begin
            z_reg  <= z_cur;
            tx_reg <= TXW'(z_cur) * TXW'(x_mag_reg);
            ty_reg <= TYW'(z_cur) * TYW'(y_mag_reg);
        end
        if (cmd.part)
        begin
            // The distance product is too wide for one multiplier, so it is
            // split into a low and a high slice.
            px_lo_reg <= (SPLIT_W + INV_W)'(tx_reg[SPLIT_W-1:0])
                       * (SPLIT_W + INV_W)'(inv_focal_x_reg);
            px_hi_reg <= (TXW - SPLIT_W + INV_W)'(tx_reg[TXW-1:SPLIT_W])
                       * (TXW - SPLIT_W + INV_W)'(inv_focal_x_reg);
            py_lo_reg <= (SPLIT_W + INV_W)'(ty_reg[SPLIT_W-1:0])
                       * (SPLIT_W + INV_W)'(inv_focal_y_reg);
            py_hi_reg <= (TYW - SPLIT_W + INV_W)'(ty_reg[TYW-1:SPLIT_W])
                       * (TYW - SPLIT_W + INV_W)'(inv_focal_y_reg);
        end
        if (cmd.sum)
        begin
            px_reg <= (PXW'(px_hi_reg) << SPLIT_W) + PXW'(px_lo_reg);
            py_reg <= (PYW'(py_hi_reg) << SPLIT_W) + PYW'(py_lo_reg);
        end
        if (cmd.load_out)
        begin
            point_reg.point_x   <= fix_coord(PMW'(px_reg), x_neg_reg);
            point_reg.point_y   <= fix_coord(PMW'(py_reg), y_neg_reg);
            point_reg.point_z   <= z_reg;
            point_reg.color_out <= color_reg;
            point_reg.row_end   <= row_end_reg;
        end
    end

    assign point = point_reg;

endmodule

// ===== hw/rtl/dcp_checker.sv =====
`timescale 1ns / 1ps

module dcp_checker
(
    input logic            clk,
    input logic            rst_n,
    input logic            pixel_valid,
    input logic            pixel_stall,
    input logic            point_valid,
    input logic            point_stall,
    input dcp_pkg::point_t point
);
    import dcp_pkg::*;

    // A waiting point word stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_stall |=> point_valid)
        else $error("point word dropped while stalled");

    // A waiting point word keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_stall |=> $stable(point))
        else $error("point word changed while stalled");

    // Only one pixel is worked on at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_stall |=> pixel_stall)
        else $error("second pixel accepted while one is in flight");

    // Depth stays within the range of a 16-bit millimeter reading.
    assert property (@(posedge clk) disable iff (!rst_n)
        point_valid |-> point.point_z <= 23'd4294901)
        else $error("point_z out of range");

    // A zero depth reading puts the point at the origin.
    assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point.point_z == '0 |->
            point.point_x == '0 && point.point_y == '0)
        else $error("zero depth gave a nonzero coordinate");

endmodule

bind depth_color_to_point_xyzrgba dcp_checker u_dcp_checker (.*);

// ===== tb/sv/depth_color_to_point_xyzrgba_checker.sv =====
`timescale 1ns / 1ps

module depth_color_to_point_xyzrgba_checker
    import dcp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    input  logic                  pixel_stall,
    input  pixel_t                pixel,
    input  logic                  point_valid,
    input  logic                  point_stall,
    input  point_t                point,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    error_count,
    output int                    pending_points
);

    logic [INV_W-1:0]     inv_fx;
    logic [INV_W-1:0]     inv_fy;
    logic [CENTER_W-1:0]  ctr_x;
    logic [CENTER_W-1:0]  ctr_y;
    logic [ROW_LEN_W-1:0] line_len;
    int unsigned          column;
    int unsigned          row;
    point_t               expected_points[$];

    initial begin
        error_count    = 0;
        pending_points = 0;
    end

    // z * offset * inv >> 28 rounded toward minus infinity, clamped to 32 signed bits.
    function automatic logic [COORD_W-1:0] project_axis(logic [Z_W-1:0] z, longint offset,
                                                        logic [INV_W-1:0] inv);
        logic [79:0] mag;
        logic [79:0] prod;
        logic [79:0] q;
        mag  = (offset < 0) ? 80'(-offset) : 80'(offset);
        prod = 80'(z) * mag * 80'(inv);
        q    = prod >> FRAC_SHIFT;
        if (offset < 0) begin
            if (prod[FRAC_SHIFT-1:0] != '0)
                q = q + 80'd1;
            if (q > 80'h8000_0000)
                q = 80'h8000_0000;
            q = -q;
            return q[COORD_W-1:0];
        end
        if (q > 80'h7FFF_FFFF)
            q = 80'h7FFF_FFFF;
        return q[COORD_W-1:0];
    endfunction

    // Back-projects one pixel and advances the raster position.
    function automatic point_t predict_point(pixel_t px);
        point_t      pt;
        logic [31:0] z_full;
        int unsigned len;
        longint      dx;
        longint      dy;
        logic        last;
        len = line_len;
        if (len == 0)
            len = 1;
        if (len > DEF_MAX_COLUMNS)
            len = DEF_MAX_COLUMNS;
        if (px.frame_start) begin
            column = 0;
            row    = 0;
        end
        z_full = {px.depth_mm, 16'd0} / 32'd1000;
        dx     = longint'(column) * 16 - longint'(ctr_x);
        dy     = longint'(ctr_y) - longint'(row) * 16;
        last   = (column + 1) >= len;

        pt.point_x   = project_axis(z_full[Z_W-1:0], dx, inv_fx);
        pt.point_y   = project_axis(z_full[Z_W-1:0], dy, inv_fy);
        pt.point_z   = z_full[Z_W-1:0];
        pt.color_out = px.color_bgra;
        pt.row_end   = last;

        if (last) begin
            column = 0;
            row    = (row + 1 >= DEF_MAX_ROWS) ? 0 : row + 1;
        end else begin
            column = column + 1;
        end
        return pt;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        point_t exp_pt;
        if (!rst_n) begin
            inv_fx   = RST_INV_FOCAL_X;
            inv_fy   = RST_INV_FOCAL_Y;
            ctr_x    = RST_CENTER_X;
            ctr_y    = RST_CENTER_Y;
            line_len = RST_ROW_LENGTH;
            column   = 0;
            row      = 0;
            expected_points.delete();
            pending_points = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_INV_FOCAL_X: inv_fx   = cfg_data[INV_W-1:0];
                    REG_INV_FOCAL_Y: inv_fy   = cfg_data[INV_W-1:0];
                    REG_CENTER_X:    ctr_x    = cfg_data[CENTER_W-1:0];
                    REG_CENTER_Y:    ctr_y    = cfg_data[CENTER_W-1:0];
                    REG_ROW_LENGTH:  line_len = cfg_data[ROW_LEN_W-1:0];
                    default: ;
                endcase
            end

            if (point_valid && !point_stall) begin
                if (expected_points.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("point word with none expected: x=%0d y=%0d z=%0d",
                                 point.point_x, point.point_y, point.point_z);
                end else begin
                    exp_pt = expected_points.pop_front();
                    if (point.point_x !== exp_pt.point_x || point.point_y !== exp_pt.point_y ||
                        point.point_z !== exp_pt.point_z ||
                        point.color_out !== exp_pt.color_out ||
                        point.row_end !== exp_pt.row_end) begin
                        error_count++;
                        if (error_count <= 10)
                            $display({"point mismatch: expected x=%0d y=%0d z=%0d color=%h ",
                                      "row_end=%b, got x=%0d y=%0d z=%0d color=%h row_end=%b"},
                                     exp_pt.point_x, exp_pt.point_y, exp_pt.point_z,
                                     exp_pt.color_out, exp_pt.row_end,
                                     point.point_x, point.point_y, point.point_z,
                                     point.color_out, point.row_end);
                    end
                end
            end

            if (pixel_valid && !pixel_stall)
                expected_points = {expected_points, predict_point(pixel)};
            pending_points = expected_points.size();
        end
    end

endmodule

// ===== tb/sv/depth_color_to_point_xyzrgba_tb.sv =====
`timescale 1ns / 1ps

module depth_color_to_point_xyzrgba_tb;
    import dcp_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int ROW_RUN_PIXELS = 24;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_RUNS
    } stall_mode_e;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  pixel_valid = 1'b0;
    logic                  pixel_stall;
    pixel_t                pixel       = '0;
    logic                  point_valid;
    logic                  point_stall = 1'b0;
    point_t                point;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = REG_INV_FOCAL_X;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    int          error_count;
    int          pending_points;
    logic        pixel_taken = 1'b0;
    int          burst_left  = 0;
    int          cycle_count = 0;
    int          stall_tick  = 0;
    int          stall_run   = 0;
    stall_mode_e stall_mode  = STALL_NONE;

    depth_color_to_point_xyzrgba dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    depth_color_to_point_xyzrgba_checker point_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .pixel_valid    (pixel_valid),
        .pixel_stall    (pixel_stall),
        .pixel          (pixel),
        .point_valid    (point_valid),
        .point_stall    (point_stall),
        .point          (point),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .error_count    (error_count),
        .pending_points (pending_points)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Records whether the pixel word was taken at this edge; read at the next falling edge.
    always @(posedge clk)
    begin
        pixel_taken <= pixel_valid && !pixel_stall;
    end

    // The point side switches between randomly chosen stall patterns.
    always @(negedge clk)
    begin
        stall_tick++;
        if (stall_tick % 300 == 0)
            stall_mode = stall_mode_e'($urandom_range(0, 3));
        case (stall_mode)
            STALL_NONE:     point_stall = 1'b0;
            STALL_RANDOM:   point_stall = ($urandom_range(0, 2) == 0);
            STALL_PERIODIC: point_stall = (stall_tick % 5) < 3;
            default:
            begin
                if (stall_run == 0) begin
                    point_stall = ~point_stall;
                    stall_run   = $urandom_range(1, 12);
                end else begin
                    stall_run--;
                end
            end
        endcase
    end

    task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic settle();
        pixel_valid = 1'b0;
        while (pending_points != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Unused upper data bits carry noise; the registers must ignore them.
    task automatic set_camera(logic [INV_W-1:0] ifx, logic [INV_W-1:0] ify,
                              logic [CENTER_W-1:0] cx, logic [CENTER_W-1:0] cy,
                              logic [ROW_LEN_W-1:0] len);
        settle();
        write_reg(REG_INV_FOCAL_X, ifx);
        write_reg(REG_INV_FOCAL_Y, ify);
        write_reg(REG_CENTER_X, {8'($urandom), cx});
        write_reg(REG_CENTER_Y, {8'($urandom), cy});
        write_reg(REG_ROW_LENGTH, {11'($urandom), len});
    endtask

    task automatic send_pixel(logic [DEPTH_W-1:0] depth, logic [COLOR_W-1:0] color, logic fs);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 3) != 0) begin
                gap         = $urandom_range(1, 12);
                pixel_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        pixel.depth_mm    = depth;
        pixel.color_bgra  = color;
        pixel.frame_start = fs;
        pixel_valid       = 1'b1;
        @(negedge clk);
        while (!pixel_taken)
            @(negedge clk);
    endtask

    function automatic logic [DEPTH_W-1:0] pick_depth();
        int sel;
        sel = $urandom_range(0, 7);
        case (sel)
            0:       return '0;
            1:       return '1;
            2, 3:    return DEPTH_W'($urandom);
            default: return DEPTH_W'($urandom_range(300, 8000));
        endcase
    endfunction

    function automatic logic [INV_W-1:0] pick_inverse();
        int sel;
        sel = $urandom_range(0, 4);
        case (sel)
            0:       return '0;
            1:       return '1;
            2:       return INV_W'($urandom);
            default: return INV_W'($urandom_range(20000, 40000));
        endcase
    endfunction

    function automatic logic [CENTER_W-1:0] pick_center();
        int sel;
        sel = $urandom_range(0, 4);
        case (sel)
            0:       return '0;
            1:       return '1;
            2:       return CENTER_W'($urandom);
            default: return CENTER_W'($urandom_range(0, 640 * 16));
        endcase
    endfunction

    function automatic logic [ROW_LEN_W-1:0] pick_length();
        int sel;
        sel = $urandom_range(0, 7);
        case (sel)
            0:       return '0;
            1:       return ROW_LEN_W'(1);
            2:       return ROW_LEN_W'($urandom_range(2, 16));
            3:       return ROW_LEN_W'(DEF_MAX_COLUMNS);
            4:       return ROW_LEN_W'($urandom_range(DEF_MAX_COLUMNS + 1, 8191));
            5:       return '1;
            default: return ROW_LEN_W'($urandom_range(1, 700));
        endcase
    endfunction

    initial
    begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset camera values: zero depth, full depth, and bit patterns in the color word.
        send_pixel(16'd0, 32'h0000_0000, 1'b1);
        send_pixel(16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        send_pixel(16'd1, 32'hA5A5_A5A5, 1'b0);
        send_pixel(16'd1000, 32'h5A5A_5A5A, 1'b1);
        send_pixel(16'h8000, 32'h0123_4567, 1'b0);

        // Largest scale drives x to negative and y to positive saturation; a zero
        // row length gives a row end on every word.
        set_camera('1, '1, '1, '1, '0);
        repeat (3) send_pixel('1, $urandom, 1'b0);

        // Row length past the column limit, principal point at the origin.
        set_camera('1, '1, '0, '0, '1);
        send_pixel('1, $urandom, 1'b1);
        repeat (2) send_pixel('1, $urandom, 1'b0);

        // Zero focal reciprocals, then the row length drops below the current column.
        set_camera('0, '0, 16'd5429, 16'd3884, 13'd8);
        send_pixel(16'd2500, $urandom, 1'b1);
        repeat (4) send_pixel(pick_depth(), $urandom, 1'b0);
        set_camera(RST_INV_FOCAL_X, RST_INV_FOCAL_Y, RST_CENTER_X, RST_CENTER_Y, 13'd2);
        repeat (2) send_pixel(pick_depth(), $urandom, 1'b0);

        for (int phase = 0; phase < 8; phase++) begin
            set_camera(pick_inverse(), pick_inverse(), pick_center(), pick_center(),
                       pick_length());
            for (int k = 0; k < 90; k++) begin
                if (k == 45 && $urandom_range(0, 1) == 1)
                    settle();
                send_pixel(pick_depth(), $urandom, $urandom_range(0, 63) == 0);
            end
        end

        // One pixel per row, so every word ends its row and the row count climbs.
        set_camera(RST_INV_FOCAL_X, RST_INV_FOCAL_Y, RST_CENTER_X, RST_CENTER_Y, 13'd1);
        send_pixel(pick_depth(), $urandom, 1'b1);
        repeat (ROW_RUN_PIXELS) send_pixel(pick_depth(), $urandom, 1'b0);

        settle();
        if (error_count == 0 && pending_points == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/dcp_pkg.sv
hw/rtl/dcp_ctrl.sv
hw/rtl/dcp_datapath.sv
hw/rtl/depth_color_to_point_xyzrgba.sv
hw/rtl/dcp_checker.sv
tb/sv/depth_color_to_point_xyzrgba_checker.sv
tb/sv/depth_color_to_point_xyzrgba_tb.sv
